FILE: hdl/esr_pkg.sv
// ----------------------------------------------------------------------------
// Euclidean similarity ranker package
// Shared constants, state encoding and controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package esr_pkg;

  localparam int MAX_USERS  = 64;
  localparam int MAX_ITEMS  = 128;
  localparam int USER_W     = $clog2(MAX_USERS);
  localparam int ITEM_W     = $clog2(MAX_ITEMS);
  localparam int UCNT_W     = 7;
  localparam int ICNT_W     = 8;
  localparam int RATING_W   = 16;
  localparam int SIM_W      = 16;
  localparam int PROD_W     = 32;
  localparam int SUM_W      = 40;
  localparam int ROOT_W     = SUM_W + 1;
  localparam int DIVR_W     = 21;
  localparam int QUO_W      = 24;
  localparam int DCNT_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_USER_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT = 1'd1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_SUM_RD,
    ST_SQ_LOAD,
    ST_SQ_RUN,
    ST_DV_LOAD,
    ST_DV_RUN,
    ST_SIM_WR,
    ST_SCAN_INIT,
    ST_SCAN_RD,
    ST_SCAN_END,
    ST_EMIT
  } esr_state_t;

  typedef struct packed {
    logic in_ready;
    logic sum_rd;
    logic sq_load;
    logic sq_step;
    logic dv_load;
    logic dv_step;
    logic sim_wr;
    logic scan_init;
    logic scan_rd;
    logic emit;
  } esr_cmd_t;

  typedef struct packed {
    logic final_accept;
    logic sq_last;
    logic dv_last;
    logic k_last;
    logic scan_last;
    logic emit_last;
    logic out_free;
  } esr_status_t;

endpackage

`default_nettype wire

FILE: hdl/esr_rating_if.sv
// ----------------------------------------------------------------------------
// Rating stream interface
// Valid/ready channel that carries one signed Q8.8 rating per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface esr_rating_if
  import esr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [RATING_W-1:0] rating;

  modport source (output valid, output rating, input ready);
  modport sink   (input valid, input rating, output ready);
endinterface

`default_nettype wire

FILE: hdl/esr_result_if.sv
// ----------------------------------------------------------------------------
// Ranking result interface
// Valid/ready channel that carries one ranked user per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface esr_result_if
  import esr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [UCNT_W-1:0] user_number;
  logic [SIM_W-1:0]  similarity;
  logic              last_of_run;

  modport source (output valid, output user_number, output similarity,
                  output last_of_run, input ready);
  modport sink   (input valid, input user_number, input similarity,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hdl/esr_ctrl.sv
// ----------------------------------------------------------------------------
// Ranker controller
// Sequences loading, scoring (root and reciprocal) and selection output.
// ----------------------------------------------------------------------------
`default_nettype none

module esr_ctrl
  import esr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire esr_status_t status,
  output esr_cmd_t         cmd
);

  esr_state_t state, state_next;
  logic       drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      drain <= (state == ST_DRAIN) && !drain;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (status.final_accept) state_next = ST_DRAIN;
      // The last squared difference passes the stage 1 and stage 2 registers before it reaches the sum memory.
      ST_DRAIN:     if (drain) state_next = ST_SUM_RD;
      ST_SUM_RD:    state_next = ST_SQ_LOAD;
      ST_SQ_LOAD:   state_next = ST_SQ_RUN;
      ST_SQ_RUN:    if (status.sq_last) state_next = ST_DV_LOAD;
      ST_DV_LOAD:   state_next = ST_DV_RUN;
      ST_DV_RUN:    if (status.dv_last) state_next = ST_SIM_WR;
      ST_SIM_WR:    state_next = status.k_last ? ST_SCAN_INIT : ST_SUM_RD;
      ST_SCAN_INIT: state_next = ST_SCAN_RD;
      ST_SCAN_RD:   if (status.scan_last) state_next = ST_SCAN_END;
      ST_SCAN_END:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) state_next = status.emit_last ? ST_LOAD : ST_SCAN_INIT;
      end
      default:      state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.in_ready  = (state == ST_LOAD);
    cmd.sum_rd    = (state == ST_SUM_RD);
    cmd.sq_load   = (state == ST_SQ_LOAD);
    cmd.sq_step   = (state == ST_SQ_RUN);
    cmd.dv_load   = (state == ST_DV_LOAD);
    cmd.dv_step   = (state == ST_DV_RUN);
    cmd.sim_wr    = (state == ST_SIM_WR);
    cmd.scan_init = (state == ST_SCAN_INIT);
    cmd.scan_rd   = (state == ST_SCAN_RD);
    cmd.emit      = (state == ST_EMIT) && status.out_free;
  end

endmodule

`default_nettype wire

FILE: hdl/esr_datapath.sv
// ----------------------------------------------------------------------------
// Ranker datapath
// Rating pipeline, sum and score memories, root and divide units, selection.
// ----------------------------------------------------------------------------
`default_nettype none

module esr_datapath
  import esr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  esr_rating_if.sink                 ratings,
  esr_result_if.source               results,
  input  wire esr_cmd_t              cmd,
  output esr_status_t                status
);

  // Configuration and effective counts.
  logic [UCNT_W-1:0] user_count;
  logic [ICNT_W-1:0] item_count;
  logic [UCNT_W-1:0] nu;
  logic [ICNT_W-1:0] ni;
  logic [USER_W-1:0] n_m1;
  logic              restart;

  always_comb begin
    if (user_count < UCNT_W'(2))              nu = UCNT_W'(2);
    else if (user_count > UCNT_W'(MAX_USERS)) nu = UCNT_W'(MAX_USERS);
    else                                      nu = user_count;
    if (item_count == '0)                     ni = ICNT_W'(1);
    else if (item_count > ICNT_W'(MAX_ITEMS)) ni = ICNT_W'(MAX_ITEMS);
    else                                      ni = item_count;
  end
  assign n_m1 = USER_W'(nu - UCNT_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      user_count <= UCNT_W'(2);
      item_count <= ICNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_USER_COUNT: user_count <= cfg_data[UCNT_W-1:0];
        REG_ITEM_COUNT: item_count <= cfg_data;
        default: ;
      endcase
    end
  end
  assign restart = cfg_we;

  // Row-major position of the next rating.
  logic [USER_W-1:0] user_idx;
  logic [ITEM_W-1:0] item_idx;
  logic              accept, row_end, run_end;

  assign ratings.ready = cmd.in_ready;
  assign accept  = ratings.valid && cmd.in_ready;
  assign row_end = ({1'b0, item_idx} + ICNT_W'(1)) >= ni;
  assign run_end = ({1'b0, user_idx} + UCNT_W'(1)) >= nu;
  assign status.final_accept = accept && row_end && run_end;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      user_idx <= '0;
      item_idx <= '0;
    end else if (accept) begin
      if (row_end) begin
        item_idx <= '0;
        user_idx <= run_end ? '0 : user_idx + USER_W'(1);
      end else begin
        item_idx <= item_idx + ITEM_W'(1);
      end
    end
  end

  // Stage 1: reference lookup.
  logic signed [RATING_W-1:0] ref_mem [MAX_ITEMS];
  logic signed [RATING_W-1:0] ref_q, r1;
  logic                       v1, is_ref1, last1;
  logic [USER_W-1:0]          user1;

  always_ff @(posedge clk) begin
    if (accept && user_idx == '0) ref_mem[item_idx] <= ratings.rating;
    ref_q   <= ref_mem[item_idx];
    r1      <= ratings.rating;
    is_ref1 <= (user_idx == '0);
    last1   <= row_end;
    user1   <= user_idx;
  end

  // Stage 2: squared difference.
  logic signed [RATING_W:0] diff;
  logic [RATING_W-1:0]      mag;
  logic [PROD_W-1:0]        prod2;
  logic                     v2, is_ref2, last2;
  logic [USER_W-1:0]        user2;

  assign diff = {ref_q[RATING_W-1], ref_q} - {r1[RATING_W-1], r1};
  // The magnitude of a 17-bit difference of two 16-bit values fits 16 bits.
  assign mag  = diff[RATING_W] ? RATING_W'(-diff) : diff[RATING_W-1:0];

  always_ff @(posedge clk) begin
    prod2   <= mag * mag;
    is_ref2 <= is_ref1;
    last2   <= last1;
    user2   <= user1;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // Stage 3: accumulate and store the row total.
  logic [SUM_W-1:0] acc, acc_sum;
  logic [SUM_W-1:0] sum_mem [MAX_USERS];
  logic [SUM_W-1:0] sum_q;
  logic [USER_W-1:0] k;

  assign acc_sum = acc + SUM_W'(prod2);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      acc <= '0;
    end else if (v2 && !is_ref2) begin
      acc <= last2 ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && !is_ref2 && last2) sum_mem[user2] <= acc_sum;
    if (cmd.sum_rd) sum_q <= sum_mem[k + USER_W'(1)];
  end

  // Digit-by-digit square root, one result bit per cycle.
  logic [ROOT_W-1:0] sq_rem, sq_root, sq_bit, sq_trial;

  assign sq_trial       = sq_root + sq_bit;
  assign status.sq_last = (sq_bit == ROOT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sq_rem  <= ROOT_W'(sum_q);
      sq_root <= '0;
      sq_bit  <= ROOT_W'(1) << (ROOT_W - 1);
    end else if (cmd.sq_step) begin
      if (sq_rem >= sq_trial) begin
        sq_rem  <= sq_rem - sq_trial;
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // Restoring division of 2^23 by (root + 256), one quotient bit per cycle.
  logic [DIVR_W-1:0] dv_div;
  logic [DIVR_W:0]   dv_rem, dv_shift;
  logic [QUO_W-1:0]  dv_quo;
  logic [DCNT_W-1:0] dv_cnt;
  logic              dv_ge;

  assign dv_shift       = {dv_rem[DIVR_W-1:0], (dv_cnt == DCNT_W'(QUO_W - 1))};
  assign dv_ge          = dv_shift >= {1'b0, dv_div};
  assign status.dv_last = (dv_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.dv_load) begin
      dv_div <= sq_root[DIVR_W-1:0] + DIVR_W'(256);
      dv_rem <= '0;
      dv_quo <= '0;
      dv_cnt <= DCNT_W'(QUO_W - 1);
    end else if (cmd.dv_step) begin
      dv_rem <= dv_ge ? dv_shift - {1'b0, dv_div} : dv_shift;
      dv_quo <= {dv_quo[QUO_W-2:0], dv_ge};
      dv_cnt <= dv_cnt - DCNT_W'(1);
    end
  end

  // Score memory and selection passes.
  logic [SIM_W-1:0]     sim_mem [MAX_USERS];
  logic [SIM_W-1:0]     sim_q, best;
  logic [USER_W-1:0]    j, cmp_idx, best_idx, emit_cnt;
  logic                 cmp_v, best_v;
  logic [MAX_USERS-1:0] emitted;

  assign status.k_last    = (k == n_m1);
  assign status.scan_last = (j == n_m1);
  assign status.emit_last = (emit_cnt == n_m1);

  always_ff @(posedge clk) begin
    if (cmd.sim_wr) sim_mem[k] <= dv_quo[SIM_W-1:0];
    if (cmd.scan_rd) sim_q <= sim_mem[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      emit_cnt <= '0;
      emitted  <= '0;
      cmp_v    <= 1'b0;
      best_v   <= 1'b0;
    end else begin
      cmp_v <= cmd.scan_rd;
      if (status.final_accept) begin
        k        <= '0;
        emit_cnt <= '0;
        emitted  <= '0;
      end
      if (cmd.sim_wr) k <= k + USER_W'(1);
      if (cmd.scan_init) begin
        best_v <= 1'b0;
      end else if (cmp_v && !emitted[cmp_idx] && (!best_v || sim_q > best)) begin
        // Strictly greater keeps the lower user number on a tie.
        best_v <= 1'b1;
      end
      if (cmd.emit) begin
        emitted[best_idx] <= 1'b1;
        emit_cnt          <= emit_cnt + USER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) j <= '0;
    else if (cmd.scan_rd) j <= j + USER_W'(1);
    cmp_idx <= j;
    if (!cmd.scan_init && cmp_v && !emitted[cmp_idx] && (!best_v || sim_q > best)) begin
      best     <= sim_q;
      best_idx <= cmp_idx;
    end
  end

  // Output register.
  logic              out_valid;
  logic [UCNT_W-1:0] out_user;
  logic [SIM_W-1:0]  out_sim;
  logic              out_last;

  assign status.out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_user <= UCNT_W'(best_idx) + UCNT_W'(2);
      out_sim  <= best;
      out_last <= status.emit_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.user_number = out_user;
  assign results.similarity  = out_sim;
  assign results.last_of_run = out_last;

endmodule

`default_nettype wire

FILE: hdl/euclidean_similarity_ranker_top.sv
// ----------------------------------------------------------------------------
// Euclidean similarity ranker
// Ranks users by root-distance similarity of their ratings to the first user.
// ----------------------------------------------------------------------------
// Ratings are taken one per cycle, row by row, with the first row kept as the
// reference; a three-stage pipeline squares differences and sums each row.
// After the final rating the block stops taking ratings: it drains the
// pipeline, then for each of the n = users-1 rows does a memory read, a root
// load and 21 root steps, a divide load and 24 divide steps, and a write,
// then runs n selection passes, one result per pass, held while the result
// side stalls. The serial root and divide units and the single-port score
// memory scans set this schedule. The user must write registers 0 (user_count)
// and 1 (item_count) only between runs; the block does not enforce this,
// and any write resets the rating position to the start of a run.
`default_nettype none

module euclidean_similarity_ranker_top
  import esr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  esr_rating_if.sink                 ratings,
  esr_result_if.source               results
);

  esr_cmd_t    cmd;
  esr_status_t status;

  esr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  esr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ratings   (ratings),
    .results   (results),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

FILE: hdl/esr_checker.sv
// ----------------------------------------------------------------------------
// Ranker port checker
// Checks result ordering and ranges as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module esr_checker
  import esr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire logic [UCNT_W-1:0] res_user,
  input wire logic [SIM_W-1:0]  res_sim,
  input wire logic              res_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_last |=> !res_valid)
    else $error("result shown after the final result of a run");

  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_sim <= SIM_W'(32768))
    else $error("similarity above 1.0");

  a_user_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_user >= UCNT_W'(2)) && (res_user <= UCNT_W'(MAX_USERS)))
    else $error("user number out of range");

endmodule

bind euclidean_similarity_ranker_top esr_checker u_esr_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_user  (results.user_number),
  .res_sim   (results.similarity),
  .res_last  (results.last_of_run)
);

`default_nettype wire

FILE: bench/esr_ranking_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Similarity ranking checker
// Watches the rating, result and register ports, predicts each ranking run
// and compares every result with the oldest predicted one.
// ----------------------------------------------------------------------------

module esr_ranking_checker
  import esr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  esr_rating_if                 ratings,
  esr_result_if                 results,
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic [UCNT_W-1:0] user_number;
    logic [SIM_W-1:0]  similarity;
    logic              last_of_run;
  } ranked_user_t;

  ranked_user_t             ranking_q[$];
  logic [UCNT_W-1:0]        user_count_reg;
  logic [ICNT_W-1:0]        item_count_reg;
  logic signed [RATING_W-1:0] reference_row[MAX_ITEMS];
  longint unsigned          row_distance[MAX_USERS];
  int                       row_pos;
  int                       col_pos;

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned rem, root, step;
    rem  = x;
    root = 0;
    step = 64'd1 << 40;
    while (step > rem) step = step >> 2;
    while (step != 0) begin
      if (rem >= root + step) begin
        rem  = rem - (root + step);
        root = (root >> 1) + step;
      end else begin
        root = root >> 1;
      end
      step = step >> 2;
    end
    return root;
  endfunction

  task automatic restart_run();
    row_pos = 0;
    col_pos = 0;
    for (int u = 0; u < MAX_USERS; u++) row_distance[u] = 0;
  endtask

  task automatic report(string field, longint got, longint want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $time, field, got, want);
    failures++;
  endtask

  // Scores every non-reference row of the finished run and queues the stable descending order.
  task automatic rank_run(int users);
    int unsigned  scores[MAX_USERS];
    int unsigned  order[MAX_USERS];
    int unsigned  sim;
    int           p;
    ranked_user_t entry;
    for (int k = 0; k < users - 1; k++) begin
      sim = int'(64'd8388608 / (floor_root(row_distance[k + 1]) + 64'd256));
      p = k;
      while (p > 0 && scores[p - 1] < sim) begin
        scores[p] = scores[p - 1];
        order[p]  = order[p - 1];
        p--;
      end
      scores[p] = sim;
      order[p]  = k + 2;
    end
    for (int k = 0; k < users - 1; k++) begin
      entry.user_number = UCNT_W'(order[k]);
      entry.similarity  = SIM_W'(scores[k]);
      entry.last_of_run = (k == users - 2);
      ranking_q.push_back(entry);
    end
  endtask

  task automatic take_rating(logic signed [RATING_W-1:0] r);
    int              users, items, diff;
    longint unsigned mag;
    users = (user_count_reg < 2) ? 2 : (user_count_reg > MAX_USERS) ? MAX_USERS
                                                                      : user_count_reg;
    items = (item_count_reg < 1) ? 1 : (item_count_reg > MAX_ITEMS) ? MAX_ITEMS
                                                                      : item_count_reg;
    if (row_pos == 0) begin
      reference_row[col_pos] = r;
    end else begin
      diff = int'(reference_row[col_pos]) - int'(r);
      mag  = longint'((diff < 0) ? -diff : diff);
      row_distance[row_pos] = (row_distance[row_pos] + mag * mag) & 64'hFF_FFFF_FFFF;
    end
    col_pos++;
    if (col_pos >= items) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= users) begin
        rank_run(users);
        restart_run();
      end
    end
  endtask

  always @(posedge clk) begin
    ranked_user_t want;
    if (rst) begin
      user_count_reg = UCNT_W'(2);
      item_count_reg = ICNT_W'(1);
      failures       = 0;
      ranking_q.delete();
      restart_run();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_USER_COUNT) user_count_reg = cfg_data[UCNT_W-1:0];
        else item_count_reg = cfg_data[ICNT_W-1:0];
        restart_run();
      end
      if (ratings.valid && ratings.ready) take_rating(ratings.rating);
      if (results.valid && results.ready) begin
        if (ranking_q.size() == 0) begin
          report("unpredicted user_number", results.user_number, 0);
        end else begin
          want = ranking_q.pop_front();
          if (results.user_number !== want.user_number)
            report("user_number", results.user_number, want.user_number);
          if (results.similarity !== want.similarity)
            report("similarity", results.similarity, want.similarity);
          if (results.last_of_run !== want.last_of_run)
            report("last_of_run", results.last_of_run, want.last_of_run);
        end
      end
    end
    pending = ranking_q.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Similarity ranker testbench
// Streams directed and random rating runs under several user and item counts,
// with random gaps and long result stalls; the checker judges every result.
// ----------------------------------------------------------------------------

module testbench;
  import esr_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE      = 10;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    pending;
  int                    ratings_sent;
  int                    stalled_cycles;
  int                    raw_users;
  int                    raw_items;
  bit                    hold_request;
  bit                    steady;

  esr_rating_if rating_ch ();
  esr_result_if result_ch ();

  euclidean_similarity_ranker_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .ratings(rating_ch), .results(result_ch)
  );

  esr_ranking_checker ranking_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .ratings(rating_ch), .results(result_ch),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Result side: random back-pressure, with one long hold-off on request.
  initial begin
    result_ch.ready = 0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        result_ch.ready <= 0;
        repeat (1500) @(posedge clk);
      end else begin
        result_ch.ready <= (pick_gap() == 0);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rating_ch.valid && rating_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic send_rating(logic signed [RATING_W-1:0] r);
    int gap;
    rating_ch.valid  <= 1;
    rating_ch.rating <= r;
    do @(posedge clk); while (!rating_ch.ready);
    ratings_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      rating_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    rating_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    stop_sending();
    wait_idle();
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 0;
    if (idx == REG_USER_COUNT) raw_users = value & 8'h7F;
    else raw_items = value;
  endtask

  // Sends one whole run; style 0 is fully random, 1 stays near the reference
  // row, 2 draws from a few values so that many users tie.
  task automatic send_run(int style);
    int users, items, spread;
    logic signed [RATING_W-1:0] ref_row[MAX_ITEMS];
    logic signed [RATING_W-1:0] r;
    users  = (raw_users < 2) ? 2 : (raw_users > MAX_USERS) ? MAX_USERS : raw_users;
    items  = (raw_items < 1) ? 1 : (raw_items > MAX_ITEMS) ? MAX_ITEMS : raw_items;
    spread = 1 << $urandom_range(0, 15);
    for (int u = 0; u < users; u++) begin
      for (int i = 0; i < items; i++) begin
        case (style)
          0: r = RATING_W'($urandom);
          1: r = (u == 0) ? RATING_W'($urandom)
                          : RATING_W'(ref_row[i] + $signed($urandom_range(0, 2 * spread))
                                      - spread);
          default: r = RATING_W'($urandom_range(0, 2) * 700);
        endcase
        if (u == 0) ref_row[i] = r;
        send_rating(r);
      end
    end
  endtask

  initial begin
    rst              = 1;
    cfg_we           = 0;
    cfg_index        = REG_USER_COUNT;
    cfg_data         = 0;
    rating_ch.valid  = 0;
    rating_ch.rating = 0;
    hold_request     = 0;
    steady           = 0;
    ratings_sent     = 0;
    raw_users        = 2;
    raw_items        = 1;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset counts: the widest possible difference, then an identical pair.
    send_rating(-16'sd32768);
    send_rating(16'sd32767);
    send_rating(16'sd5);
    send_rating(16'sd5);
    // Zero counts act as the minimum.
    write_reg(REG_USER_COUNT, 0);
    write_reg(REG_ITEM_COUNT, 0);
    send_rating(16'sd32767);
    send_rating(-16'sd32768);
    // Ties keep the lower user first.
    write_reg(REG_USER_COUNT, 4);
    write_reg(REG_ITEM_COUNT, 1);
    send_rating(16'sd0);
    send_rating(16'sd100);
    send_rating(-16'sd100);
    send_rating(16'sd100);
    // A register write in mid-run throws the partial run away.
    write_reg(REG_USER_COUNT, 3);
    write_reg(REG_ITEM_COUNT, 2);
    send_rating(16'sd1);
    send_rating(16'sd2);
    send_rating(16'sd3);
    write_reg(REG_ITEM_COUNT, 2);
    send_run(1);
    // Oversized counts clamp to the maximum, and a user count of one to the minimum.
    write_reg(REG_USER_COUNT, 127);
    write_reg(REG_ITEM_COUNT, 1);
    send_run(2);
    write_reg(REG_USER_COUNT, 1);
    write_reg(REG_ITEM_COUNT, 255);
    send_run(0);
    write_reg(REG_USER_COUNT, 64);
    write_reg(REG_ITEM_COUNT, 3);
    write_reg(REG_USER_COUNT, 2);
    send_run(1);

    // Long result hold-off while runs keep coming back to back.
    write_reg(REG_USER_COUNT, 8);
    write_reg(REG_ITEM_COUNT, 2);
    hold_request = 1;
    repeat (3) send_run($urandom_range(0, 2));

    while (ratings_sent < 450) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 9) == 0) write_reg(REG_USER_COUNT, $urandom_range(0, 1));
        else write_reg(REG_USER_COUNT, $urandom_range(2, 10));
        if ($urandom_range(0, 9) == 0) write_reg(REG_ITEM_COUNT, 0);
        else write_reg(REG_ITEM_COUNT, $urandom_range(1, 6));
      end else if ($urandom_range(0, 3) == 0) begin
        stop_sending();
        wait_idle();
      end
      send_run($urandom_range(0, 2));
    end
    steady = 0;

    stop_sending();
    wait_idle();
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
